FILE: sv/bfs_pkg.sv
// Package for the locked-edge reachability search block.
// Holds sizing constants and the request codes; no dependencies.
package bfs_pkg;
   localparam int DEF_MAX_NODES  = 256;
   localparam int DEF_MAX_DEGREE = 8;
   localparam int DEF_MAX_DOORS  = 64;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_LOCK  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_START_NODE = 1'b1;
endpackage

FILE: sv/bfs_engine.sv
// Sequenced search engine: adjacency memories, queue, visited map and
// distance memory, walked one edge per step. Depends on bfs_pkg.
module bfs_engine import bfs_pkg::*; #(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE,
   parameter int MAX_DOORS  = DEF_MAX_DOORS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] kind,
   input  logic [7:0] from_node,
   input  logic [7:0] to_node,
   input  logic       edge_has_door,
   input  logic [5:0] door_id,
   input  logic       lock_value,
   input  logic [8:0] destination,
   input  logic [8:0] node_count,
   input  logic [7:0] start_node,
   output logic       busy,
   output logic       done,
   output logic [8:0] reached_count,
   output logic       dest_reached,
   output logic [7:0] hop_count
);
   localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int CW = $clog2(MAX_DEGREE + 1);
   localparam int SW = NW + DW;
   localparam int SLOTS = 1 << SW;
   localparam int QW = $clog2(MAX_NODES + 1);
   localparam int LW = (MAX_DOORS > 1) ? $clog2(MAX_DOORS) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_ADRD, S_ADWR, S_CLR, S_INIT, S_POP, S_POPW, S_DEG, S_EDGE, S_EDGEW,
      S_CHK, S_DST, S_DSTW, S_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]      nbr_mem [SLOTS];
   logic [6:0]      tag_mem [SLOTS];
   logic [7:0]      queue_mem [MAX_NODES];
   logic [8:0]      dist_mem [MAX_NODES];
   logic [MAX_NODES-1:0] cnt_valid_ff;
   logic [CW-1:0]   cnt_mem [MAX_NODES];
   logic [MAX_NODES-1:0] visit_ff;
   logic [MAX_DOORS-1:0] lock_ff;

   logic [8:0]  n_ff;
   logic [QW-1:0] head_ff, tail_ff;
   logic [7:0]  cell_ff;
   logic [8:0]  cdist_ff;
   logic [CW-1:0] deg_ff, k_ff;
   logic [7:0]  nb_ff;
   logic [6:0]  tag_ff;
   logic [7:0]  q_rd_ff;
   logic [8:0]  d_rd_ff;
   logic [CW-1:0] c_rd_ff;
   logic [8:0]  dest_ff;
   logic [8:0]  rc_ff;
   logic        fd_ff;
   logic [7:0]  hc_ff;
   logic        done_ff;
   logic [7:0]  add_from_ff;
   logic [7:0]  add_to_ff;
   logic [6:0]  add_tag_ff;

   logic [SW-1:0] slot;
   logic          blocked;
   logic          from_ok;
   logic          add_ok;
   logic [NW-1:0] nb_idx;
   logic [NW-1:0] cnt_addr;

   assign from_ok  = ({8'd0, add_from_ff} < 16'(MAX_NODES));
   assign add_ok   = from_ok && (c_rd_ff < CW'(MAX_DEGREE));
   assign cnt_addr = (state_ff == S_ADRD) ? add_from_ff[NW-1:0] : q_rd_ff[NW-1:0];
   assign slot     = {cell_ff[NW-1:0], k_ff[DW-1:0]};
   assign nb_idx   = nb_ff[NW-1:0];
   assign blocked  = tag_ff[6] && ({26'd0, tag_ff[5:0]} < 32'(MAX_DOORS))
                     && lock_ff[tag_ff[LW-1:0]];

   // memories
   always_ff @(posedge clock) begin
      if (state_ff == S_ADWR && add_ok) begin
         nbr_mem[{add_from_ff[NW-1:0], c_rd_ff[DW-1:0]}] <= add_to_ff;
         tag_mem[{add_from_ff[NW-1:0], c_rd_ff[DW-1:0]}] <= add_tag_ff;
         cnt_mem[add_from_ff[NW-1:0]] <= c_rd_ff + 1'b1;
      end
      if (state_ff == S_EDGE) begin
         nb_ff  <= nbr_mem[slot];
         tag_ff <= tag_mem[slot];
      end
      q_rd_ff <= queue_mem[head_ff[NW-1:0]];
      c_rd_ff <= cnt_valid_ff[cnt_addr] ? cnt_mem[cnt_addr] : '0;
      d_rd_ff <= dist_mem[(state_ff == S_DST) ? dest_ff[NW-1:0] : q_rd_ff[NW-1:0]];
      if (state_ff == S_INIT) begin
         queue_mem[0] <= start_node;
         dist_mem[start_node[NW-1:0]] <= '0;
      end else if (state_ff == S_CHK && {1'b0, nb_ff} < n_ff && !visit_ff[nb_idx]
                   && !blocked) begin
         dist_mem[nb_idx] <= cdist_ff + 1'b1;
         if (tail_ff < QW'(MAX_NODES)) queue_mem[tail_ff[NW-1:0]] <= nb_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            case (kind)
               REQ_QUERY: state_in = S_CLR;
               REQ_ADD:   state_in = S_ADRD;
               default:   state_in = S_IDLE;
            endcase
         end
         S_ADRD: state_in = S_ADWR;
         S_ADWR: state_in = S_IDLE;
         S_CLR:  state_in = S_INIT;
         S_INIT: state_in = ({1'b0, start_node} < n_ff) ? S_POP : S_FIN;
         S_POP:  state_in = (head_ff < tail_ff) ? S_POPW : S_DST;
         S_POPW: state_in = S_DEG;
         S_DEG:  state_in = S_EDGE;
         S_EDGE: state_in = (k_ff < deg_ff) ? S_EDGEW : S_POP;
         S_EDGEW: state_in = S_CHK;
         S_CHK:  state_in = S_EDGE;
         S_DST:  state_in = S_DSTW;
         S_DSTW: state_in = S_FIN;
         S_FIN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_valid_ff <= '0;
         lock_ff      <= '0;
         done_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               case (kind)
                  REQ_ADD: begin
                     add_from_ff <= from_node;
                     add_to_ff   <= to_node;
                     add_tag_ff  <= {edge_has_door, door_id};
                  end
                  REQ_LOCK: if ({26'd0, door_id} < 32'(MAX_DOORS))
                     lock_ff[door_id[LW-1:0]] <= lock_value;
                  REQ_CLEAR: cnt_valid_ff <= '0;
                  default: begin
                     n_ff    <= (node_count > 9'(MAX_NODES)) ? 9'(MAX_NODES) : node_count;
                     dest_ff <= destination;
                  end
               endcase
            end
            S_ADWR: if (add_ok) cnt_valid_ff[add_from_ff[NW-1:0]] <= 1'b1;
            S_CLR: begin
               visit_ff <= '0;
               head_ff  <= '0;
               tail_ff  <= '0;
               rc_ff    <= '0;
               fd_ff    <= 1'b0;
               hc_ff    <= '0;
            end
            S_INIT: if ({1'b0, start_node} < n_ff) begin
               visit_ff[start_node[NW-1:0]] <= 1'b1;
               tail_ff <= QW'(1);
            end
            S_POP: if (head_ff < tail_ff) head_ff <= head_ff + 1'b1;
            S_POPW: cell_ff <= q_rd_ff;
            S_DEG: begin
               deg_ff   <= c_rd_ff;
               cdist_ff <= d_rd_ff;
               k_ff     <= '0;
            end
            S_EDGE: if (k_ff < deg_ff) k_ff <= k_ff + 1'b1;
            S_CHK: if ({1'b0, nb_ff} < n_ff && !visit_ff[nb_idx] && !blocked) begin
               visit_ff[nb_idx] <= 1'b1;
               if (tail_ff < QW'(MAX_NODES)) tail_ff <= tail_ff + 1'b1;
            end
            S_DST: rc_ff <= (32'(tail_ff) > 511) ? 9'd511 : 9'(tail_ff);
            S_DSTW: if (dest_ff < n_ff && visit_ff[dest_ff[NW-1:0]]) begin
               fd_ff <= 1'b1;
               hc_ff <= (d_rd_ff > 9'd255) ? 8'd255 : d_rd_ff[7:0];
            end
            S_FIN: done_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE) || done_ff;
   assign done          = done_ff;
   assign reached_count = rc_ff;
   assign dest_reached  = fd_ff;
   assign hop_count     = hc_ff;
endmodule

FILE: sv/bfs_reach_locked_edges.sv
// Lock and clear requests complete as they are accepted; an add reads the
// node's edge count, then writes the edge. A query clears the search state,
// then pops each reached node and walks its edges (read, wait, check).
// One item at a time.
// Reset (synchronous, active high) empties adjacency lists, unlocks all
// doorways and clears node_count and start_node.
module bfs_reach_locked_edges import bfs_pkg::*; #(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE,
   parameter int MAX_DOORS  = DEF_MAX_DOORS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type, from_node, to_node, edge_has_door, door_id, lock_value,
   // destination, 5 zero pad bits
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // reached_count, dest_reached, hop_count, 6 zero pad bits
   output logic [23:0] rsp_tdata
);
   logic [8:0]  node_count_ff;
   logic [7:0]  start_node_ff;
   logic        rsp_valid_ff;
   logic [17:0] rsp_data_ff;
   logic        busy, done;
   logic [8:0]  rc;
   logic        fd;
   logic [7:0]  hc;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         start_node_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_ff <= csr_wdata;
            CSR_START_NODE: start_node_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !busy && !rsp_valid_ff;

   bfs_engine #(
      .MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE), .MAX_DOORS(MAX_DOORS)
   ) u_engine (
      .clock, .reset,
      .start(req_tvalid && req_tready),
      .kind(req_tdata[1:0]),
      .from_node(req_tdata[9:2]),
      .to_node(req_tdata[17:10]),
      .edge_has_door(req_tdata[18]),
      .door_id(req_tdata[24:19]),
      .lock_value(req_tdata[25]),
      .destination(req_tdata[34:26]),
      .node_count(node_count_ff),
      .start_node(start_node_ff),
      .busy, .done,
      .reached_count(rc), .dest_reached(fd), .hop_count(hc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= {hc, fd, rc};
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};
endmodule

FILE: sv/bfs_checker.sv
// Port-level checker for bfs_reach_locked_edges, bound to the top level.
// Depends on the top-level ports only.
module bfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input accepted with response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
   a_hops_need_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[17:10] == 8'd0)
      else $error("hops without reach");
   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[8:0] != 9'd0)
      else $error("found with zero count");
endmodule

bind bfs_reach_locked_edges bfs_checker u_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

FILE: tb/sv/bfs_reach_checker.sv
// Checker for the locked-edge reachability block: tracks CSR writes and
// request transactions, predicts query responses and compares them.
// Depends on bfs_pkg.
module bfs_reach_checker import bfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          err_count,
   output int          pending
);
   localparam int NODES  = DEF_MAX_NODES;
   localparam int DEGREE = DEF_MAX_DEGREE;
   localparam int DOORS  = DEF_MAX_DOORS;

   typedef struct packed {
      logic [7:0] hops;
      logic       found;
      logic [8:0] reached;
   } reach_result_type;

   logic [8:0]  m_node_count;
   logic [7:0]  m_start;
   logic [7:0]  m_nbr   [NODES*DEGREE];
   logic        m_door  [NODES*DEGREE];
   logic [5:0]  m_door_id [NODES*DEGREE];
   int          m_degree [NODES];
   logic        m_lock  [DOORS];
   reach_result_type reach_q[$];

   function automatic reach_result_type search_reach(input logic [8:0] dest);
      reach_result_type r;
      bit visited [NODES];
      int hop_dist [NODES];
      int fifo [NODES];
      int n, head, tail, cur, slot, nb;
      n = (m_node_count > NODES) ? NODES : m_node_count;
      r = '0;
      if (m_start < n) begin
         foreach (visited[i]) visited[i] = 0;
         head = 0;
         tail = 0;
         visited[m_start] = 1;
         hop_dist[m_start] = 0;
         fifo[tail++] = m_start;
         while (head < tail) begin
            cur = fifo[head++];
            for (int k = 0; k < m_degree[cur]; k++) begin
               slot = cur * DEGREE + k;
               nb = m_nbr[slot];
               if (nb >= n || visited[nb] || (m_door[slot] && m_lock[m_door_id[slot]]))
                  continue;
               visited[nb] = 1;
               hop_dist[nb] = hop_dist[cur] + 1;
               if (tail < NODES) fifo[tail++] = nb;
            end
         end
         r.reached = (tail > 511) ? 9'd511 : tail[8:0];
         if (dest < n && visited[dest]) begin
            r.found = 1'b1;
            r.hops = (hop_dist[dest] > 255) ? 8'd255 : hop_dist[dest][7:0];
         end
      end
      return r;
   endfunction

   assign pending = reach_q.size();

   always @(posedge clock) begin
      req_kind_type kind;
      logic [7:0] from;
      reach_result_type exp_r, got;
      int errs;
      errs = 0;
      if (reset) begin
         m_node_count <= '0;
         m_start <= '0;
         foreach (m_degree[i]) m_degree[i] = 0;
         foreach (m_lock[i]) m_lock[i] = 0;
         reach_q.delete();
         err_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NODE_COUNT) m_node_count <= csr_wdata;
            else m_start <= csr_wdata[7:0];
         end
         if (req_tvalid && req_tready) begin
            kind = req_kind_type'(req_tdata[1:0]);
            from = req_tdata[9:2];
            case (kind)
               REQ_ADD: begin
                  if (m_degree[from] < DEGREE) begin
                     m_nbr[from*DEGREE + m_degree[from]] = req_tdata[17:10];
                     m_door[from*DEGREE + m_degree[from]] = req_tdata[18];
                     m_door_id[from*DEGREE + m_degree[from]] = req_tdata[24:19];
                     m_degree[from]++;
                  end
               end
               REQ_LOCK: m_lock[req_tdata[24:19]] = req_tdata[25];
               REQ_CLEAR: foreach (m_degree[i]) m_degree[i] = 0;
               default: reach_q = {reach_q, search_reach(req_tdata[34:26])};
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[17:0];
            if (reach_q.size() == 0) begin
               $error("response transaction with no query outstanding");
               errs++;
            end else begin
               exp_r = reach_q.pop_front();
               if (got.reached !== exp_r.reached) begin
                  $error("reached_count expected %0d actual %0d", exp_r.reached, got.reached);
                  errs++;
               end
               if (got.found !== exp_r.found) begin
                  $error("dest_reached expected %0d actual %0d", exp_r.found, got.found);
                  errs++;
               end
               if (got.hops !== exp_r.hops) begin
                  $error("hop_count expected %0d actual %0d", exp_r.hops, got.hops);
                  errs++;
               end
            end
         end
         err_count <= err_count + errs;
      end
   end
endmodule

FILE: tb/sv/bfs_reach_locked_edges_tb.sv
// Top of the reachability block testbench: clock, reset, request and CSR
// stimulus, response back-pressure, watchdog and verdict.
// Depends on bfs_pkg, bfs_reach_locked_edges and bfs_reach_checker.
module bfs_reach_locked_edges_tb;
   import bfs_pkg::*;

   localparam int QUIET_CYCLES = 2500;
   localparam int WATCHDOG_LIMIT = 50000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = CSR_NODE_COUNT;
   logic [8:0]  csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   int          err_count, pending;
   int          idle_cycles = 0;
   int          node_lim = 1;
   bit          stim_done = 0;

   always #5 clock = ~clock;

   bfs_reach_locked_edges dut (.*);

   bfs_reach_checker checker_i (.*);

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) rsp_tready <= (pick_gap() == 0);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send(input req_kind_type kind, input logic [7:0] from, input logic [7:0] to,
                       input logic has_door, input logic [5:0] door, input logic lockv,
                       input logic [8:0] dest);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {5'd0, dest, lockv, door, has_door, to, from, kind};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic settle_and_config(input logic [8:0] count, input logic [7:0] start);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      csr_we <= 1;
      csr_index <= CSR_NODE_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= CSR_START_NODE;
      csr_wdata <= {1'b0, start};
      @(posedge clock);
      csr_we <= 0;
      node_lim = (count == 0) ? 1 : (count > 256 ? 256 : count);
   endtask

   function automatic logic [7:0] any_node();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, node_lim - 1));
   endfunction

   initial begin
      int r;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty graph, node_count zero
      send(REQ_QUERY, 0, 0, 0, 0, 0, 0);
      settle_and_config(9'd8, 8'd0);
      send(REQ_ADD, 0, 1, 0, 0, 0, 0);
      send(REQ_ADD, 1, 2, 1, 6'd63, 0, 0);
      send(REQ_ADD, 2, 7, 1, 6'd5, 0, 0);
      send(REQ_ADD, 0, 200, 0, 0, 0, 0);
      send(REQ_ADD, 255, 0, 1, 6'd1, 1, 9'h1ff);
      for (int i = 0; i < 9; i++) send(REQ_ADD, 3, 8'(i), 0, 0, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd7);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd8);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'h1ff);
      send(REQ_LOCK, 0, 0, 0, 6'd63, 1, 0);
      send(REQ_LOCK, 0, 0, 0, 6'd5, 1, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd2);
      send(REQ_LOCK, 0, 0, 0, 6'd63, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd7);
      send(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd0);
      settle_and_config(9'd8, 8'd9);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd0);
      settle_and_config(9'h1ff, 8'd255);
      send(REQ_ADD, 255, 254, 0, 0, 0, 0);
      send(REQ_QUERY, 0, 0, 0, 0, 0, 9'd254);
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: settle_and_config(9'd16, 8'd0);
            1: settle_and_config(9'd256, 8'($urandom_range(0, 255)));
            2: settle_and_config(9'($urandom_range(2, 64)), 8'($urandom_range(0, 3)));
            default: settle_and_config(9'($urandom_range(0, 511)), 8'($urandom));
         endcase
         for (int i = 0; i < 60; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
               send(REQ_ADD, any_node(), any_node(), 1'($urandom), 6'($urandom), 1'($urandom),
                    9'($urandom));
            else if (r < 70)
               send(REQ_LOCK, 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom),
                    1'($urandom), 9'($urandom));
            else if (r < 97)
               send(REQ_QUERY, 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom),
                    1'($urandom), ($urandom_range(0, 4) == 0) ? 9'($urandom)
                                  : 9'($urandom_range(0, node_lim - 1)));
            else
               send(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'($urandom), 6'($urandom),
                    1'($urandom), 9'($urandom));
         end
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: files.f
sv/bfs_pkg.sv
sv/bfs_engine.sv
sv/bfs_reach_locked_edges.sv
sv/bfs_checker.sv
tb/sv/bfs_reach_checker.sv
tb/sv/bfs_reach_locked_edges_tb.sv
